// ===== src/gsal_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsal_pkg
// shared types and constants of the gas sensor average and linearize unit
// ----------------------------------------------------------------------------
package gsal_pkg;

    // sample averaging
    localparam int SAMPLES     = 8;
    localparam int SAMPLE_BITS = 23;
    localparam int AVG_SHIFT   = $clog2(SAMPLES);
    localparam int SUM_W       = SAMPLE_BITS + AVG_SHIFT;
    localparam int CNT_W       = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;

    // field widths
    localparam int MEAN_W  = 23;
    localparam int LEVEL_W = 16;
    localparam int SEC_W   = 12;
    localparam int CD_W    = 13;
    localparam int OP_W    = 2;

    // serial multiply / divide: one bit of the level-wide operand per step
    localparam int STEP_W = $clog2(LEVEL_W);

    // apb
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef logic [OP_W-1:0] op_t;
    localparam op_t OP_SAMPLE   = 2'd0;
    localparam op_t OP_TICK     = 2'd1;
    localparam op_t OP_POWER_ON = 2'd2;

    typedef logic [2:0] reg_idx_t;
    localparam reg_idx_t REG_ADC_POINT_0    = 3'd0;
    localparam reg_idx_t REG_ADC_POINT_1    = 3'd1;
    localparam reg_idx_t REG_ADC_POINT_2    = 3'd2;
    localparam reg_idx_t REG_LEVEL_AT_0     = 3'd3;
    localparam reg_idx_t REG_LEVEL_AT_1     = 3'd4;
    localparam reg_idx_t REG_LEVEL_AT_2     = 3'd5;
    localparam reg_idx_t REG_WARMUP_SECONDS = 3'd6;

    localparam logic [MEAN_W-1:0]  RST_ADC_POINT_0    = 23'd325000;
    localparam logic [MEAN_W-1:0]  RST_ADC_POINT_1    = 23'd1400000;
    localparam logic [MEAN_W-1:0]  RST_ADC_POINT_2    = 23'd1890000;
    localparam logic [LEVEL_W-1:0] RST_LEVEL_AT_0     = 16'd0;
    localparam logic [LEVEL_W-1:0] RST_LEVEL_AT_1     = 16'd130;
    localparam logic [LEVEL_W-1:0] RST_LEVEL_AT_2     = 16'd300;
    localparam logic [SEC_W-1:0]   RST_WARMUP_SECONDS = 12'd180;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

    // control of the serial multiply / divide unit
    typedef struct packed {
        logic load;
        logic mul_step;
        logic div_step;
    } md_ctrl_t;

endpackage

// ===== src/gsal_muldiv.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsal_muldiv
// bit-serial shift-add multiplier followed by restoring divider
// ----------------------------------------------------------------------------
module gsal_muldiv (
    input  logic                          aclk,
    input  gsal_pkg::md_ctrl_t            ctrl,
    input  logic [gsal_pkg::MEAN_W-1:0]   mcand,
    input  logic [gsal_pkg::LEVEL_W-1:0]  mplier,
    input  logic [gsal_pkg::MEAN_W-1:0]   divisor,
    output logic [gsal_pkg::LEVEL_W-1:0]  quotient
);
    import gsal_pkg::*;

    logic [MEAN_W-1:0]  hi_reg;
    logic [LEVEL_W-1:0] lo_reg;
    logic [MEAN_W-1:0]  mcand_reg;
    logic [MEAN_W-1:0]  den_reg;

    logic [MEAN_W:0]    mul_sum;
    logic [MEAN_W:0]    div_rem;
    logic [MEAN_W:0]    div_diff;
    logic               div_ge;

    // product lives in {hi, lo}; the divider shifts lo into hi and quotient bits into lo
    always_comb begin
        mul_sum  = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, mcand_reg} : '0);
        div_rem  = {hi_reg, lo_reg[LEVEL_W-1]};
        div_ge   = (div_rem >= {1'b0, den_reg});
        div_diff = div_rem - {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            hi_reg    <= '0;
            lo_reg    <= mplier;
            mcand_reg <= mcand;
            den_reg   <= divisor;
        end else if (ctrl.mul_step) begin
            hi_reg <= mul_sum[MEAN_W:1];
            lo_reg <= {mul_sum[0], lo_reg[LEVEL_W-1:1]};
        end else if (ctrl.div_step) begin
            hi_reg <= div_ge ? div_diff[MEAN_W-1:0] : div_rem[MEAN_W-1:0];
            lo_reg <= {lo_reg[LEVEL_W-2:0], div_ge};
        end
    end

    assign quotient = lo_reg;

endmodule

// ===== src/gas_sensor_average_and_linearize_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gas_sensor_average_and_linearize_unit
// sensor sample averaging with three-breakpoint linear calibration
// ----------------------------------------------------------------------------
// Each input transaction is a converter sample, a one-second tick or a
// power-on event. Samples are summed; every eighth sample produces one
// result transaction with the mean, a calibrated level interpolated between
// three programmable breakpoints (zero at or below the first, the last level
// past the table), a ready flag and a negative seconds countdown while
// the sensor is warming up. Ticks, power-on events and samples that do not
// close a group are taken while the sequencer stays idle. A closing sample
// on an interpolated segment passes through a setup state, the bit-serial
// multiplier, the radix-2 divider that shares its registers, and a final
// state that forms the level for the output register. A mean at or below
// the first breakpoint or past the table skips the multiply and divide and
// goes from setup to the final state. The input is held off while the level
// is computed. The output register lets new input transactions in while a
// result waits; a second closing sample then waits in its final state until
// the first result is taken. Breakpoints, levels and the warm-up time must
// be written through the APB port only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module gas_sensor_average_and_linearize_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input transactions
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [gsal_pkg::OP_W-1:0]          s_op,
    input  logic [gsal_pkg::SAMPLE_BITS-1:0]   s_sample,
    // result transactions
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [gsal_pkg::MEAN_W-1:0]        m_mean_sample,
    output logic [gsal_pkg::LEVEL_W-1:0]       m_level,
    output logic                               m_ready_res,
    output logic signed [gsal_pkg::CD_W-1:0]   m_countdown,
    // configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [gsal_pkg::ADDR_W-1:0]        paddr,
    input  logic [gsal_pkg::DATA_W-1:0]        pwdata,
    output logic [gsal_pkg::DATA_W-1:0]        prdata,
    output logic                               pready
);
    import gsal_pkg::*;

    // configuration registers
    logic [MEAN_W-1:0]  adc_point_0_reg;
    logic [MEAN_W-1:0]  adc_point_1_reg;
    logic [MEAN_W-1:0]  adc_point_2_reg;
    logic [LEVEL_W-1:0] level_at_0_reg;
    logic [LEVEL_W-1:0] level_at_1_reg;
    logic [LEVEL_W-1:0] level_at_2_reg;
    logic [SEC_W-1:0]   warmup_seconds_reg;

    // accumulator and warm-up state
    logic [SUM_W-1:0]   sample_sum_reg;
    logic [SUM_W-1:0]   sample_sum_next;
    logic [CNT_W-1:0]   sample_count_reg;
    logic [SEC_W-1:0]   elapsed_reg;
    logic [SEC_W-1:0]   elapsed_next;
    logic               warm_reg;

    // captured at the closing sample
    logic [MEAN_W-1:0]  mean_reg;
    logic               ready_res_reg;
    logic [CD_W-1:0]    countdown_reg;

    // level computation
    state_t             state_reg;
    state_t             state_next;
    logic [STEP_W-1:0]  step_reg;
    logic               use_div_reg;
    logic               neg_reg;
    logic [LEVEL_W-1:0] base_reg;
    logic [LEVEL_W-1:0] direct_reg;

    // output register
    logic               m_valid_reg;
    logic [MEAN_W-1:0]  m_mean_reg;
    logic [LEVEL_W-1:0] m_level_reg;
    logic               m_ready_res_reg;
    logic [CD_W-1:0]    m_countdown_reg;

    logic               s_fire;
    logic               cfg_wr;
    reg_idx_t           cfg_idx;
    logic               group_done;
    logic [CD_W-1:0]    countdown_now;

    // segment selection in the setup cycle
    logic               below_p0;
    logic               below_p1;
    logic               below_p2;
    logic [MEAN_W-1:0]  seg_pa;
    logic [MEAN_W-1:0]  seg_pb;
    logic [LEVEL_W-1:0] seg_la;
    logic [LEVEL_W-1:0] seg_lb;
    logic [LEVEL_W:0]   seg_dl;
    logic [LEVEL_W:0]   seg_dl_mag;
    logic [MEAN_W-1:0]  md_mcand;
    logic [MEAN_W-1:0]  md_den;
    logic [LEVEL_W-1:0] md_mplier;
    logic [LEVEL_W-1:0] md_quot;
    md_ctrl_t           md_ctrl;

    logic               out_load;
    logic [LEVEL_W-1:0] level_final;
    logic               step_last;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[ADDR_W-1:2];

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            adc_point_0_reg    <= RST_ADC_POINT_0;
            adc_point_1_reg    <= RST_ADC_POINT_1;
            adc_point_2_reg    <= RST_ADC_POINT_2;
            level_at_0_reg     <= RST_LEVEL_AT_0;
            level_at_1_reg     <= RST_LEVEL_AT_1;
            level_at_2_reg     <= RST_LEVEL_AT_2;
            warmup_seconds_reg <= RST_WARMUP_SECONDS;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_ADC_POINT_0:    adc_point_0_reg    <= pwdata[MEAN_W-1:0];
                REG_ADC_POINT_1:    adc_point_1_reg    <= pwdata[MEAN_W-1:0];
                REG_ADC_POINT_2:    adc_point_2_reg    <= pwdata[MEAN_W-1:0];
                REG_LEVEL_AT_0:     level_at_0_reg     <= pwdata[LEVEL_W-1:0];
                REG_LEVEL_AT_1:     level_at_1_reg     <= pwdata[LEVEL_W-1:0];
                REG_LEVEL_AT_2:     level_at_2_reg     <= pwdata[LEVEL_W-1:0];
                REG_WARMUP_SECONDS: warmup_seconds_reg <= pwdata[SEC_W-1:0];
                default: ;  // writes past the register list are dropped
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_ADC_POINT_0:    prdata = DATA_W'(adc_point_0_reg);
            REG_ADC_POINT_1:    prdata = DATA_W'(adc_point_1_reg);
            REG_ADC_POINT_2:    prdata = DATA_W'(adc_point_2_reg);
            REG_LEVEL_AT_0:     prdata = DATA_W'(level_at_0_reg);
            REG_LEVEL_AT_1:     prdata = DATA_W'(level_at_1_reg);
            REG_LEVEL_AT_2:     prdata = DATA_W'(level_at_2_reg);
            REG_WARMUP_SECONDS: prdata = DATA_W'(warmup_seconds_reg);
            default:            prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // input side: accumulate samples, count seconds
    // ------------------------------------------------------------------
    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid & s_ready;

    assign sample_sum_next = sample_sum_reg + SUM_W'(s_sample);
    assign group_done      = (sample_count_reg == CNT_W'(SAMPLES - 1));

    // saturating seconds counter
    assign elapsed_next = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + 1'b1;

    // negative distance to the end of warm-up, zero once reached or warm
    always_comb begin
        if (warm_reg || (elapsed_reg >= warmup_seconds_reg)) begin
            countdown_now = '0;
        end else begin
            countdown_now = {1'b0, elapsed_reg} - {1'b0, warmup_seconds_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_sum_reg   <= '0;
            sample_count_reg <= '0;
            elapsed_reg      <= '0;
            warm_reg         <= 1'b0;
        end else if (s_fire) begin
            case (s_op)
                OP_SAMPLE: begin
                    if (group_done) begin
                        sample_sum_reg   <= '0;
                        sample_count_reg <= '0;
                    end else begin
                        sample_sum_reg   <= sample_sum_next;
                        sample_count_reg <= sample_count_reg + 1'b1;
                    end
                end
                OP_TICK: begin
                    elapsed_reg <= elapsed_next;
                    if (elapsed_next >= warmup_seconds_reg) begin
                        warm_reg <= 1'b1;
                    end
                end
                OP_POWER_ON: begin
                    elapsed_reg <= '0;
                    warm_reg    <= 1'b0;
                end
                default: ;  // unused op code is taken and ignored
            endcase
        end
    end

    // snapshot of the closing sample's mean and warm-up status
    always_ff @(posedge aclk) begin
        if (s_fire && (s_op == OP_SAMPLE) && group_done) begin
            mean_reg      <= MEAN_W'(sample_sum_next >> AVG_SHIFT);
            ready_res_reg <= warm_reg;
            countdown_reg <= countdown_now;
        end
    end

    // ------------------------------------------------------------------
    // level computation sequencer
    // ------------------------------------------------------------------
    assign step_last = (step_reg == STEP_W'(LEVEL_W - 1));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && (s_op == OP_SAMPLE) && group_done) begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                if (below_p0 || (!below_p1 && !below_p2)) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                if (step_last) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (step_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        md_ctrl  = '0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_SETUP: md_ctrl.load     = 1'b1;
            ST_MUL:   md_ctrl.mul_step = 1'b1;
            ST_DIV:   md_ctrl.div_step = 1'b1;
            ST_DONE:  out_load         = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if ((state_reg == ST_MUL) || (state_reg == ST_DIV)) begin
                step_reg <= step_reg + 1'b1;
            end else begin
                step_reg <= '0;
            end
        end
    end

    // segment choice: at or below p0 gives zero, below p1 the first segment,
    // else below p2 the second, else the last level
    always_comb begin
        below_p0 = (mean_reg <= adc_point_0_reg);
        below_p1 = (mean_reg <  adc_point_1_reg);
        below_p2 = (mean_reg <  adc_point_2_reg);
        if (below_p1) begin
            seg_pa = adc_point_0_reg;
            seg_pb = adc_point_1_reg;
            seg_la = level_at_0_reg;
            seg_lb = level_at_1_reg;
        end else begin
            seg_pa = adc_point_1_reg;
            seg_pb = adc_point_2_reg;
            seg_la = level_at_1_reg;
            seg_lb = level_at_2_reg;
        end
        seg_dl     = {1'b0, seg_lb} - {1'b0, seg_la};
        seg_dl_mag = seg_dl[LEVEL_W] ? (~seg_dl + 1'b1) : seg_dl;
        md_mcand   = mean_reg - seg_pa;
        md_den     = seg_pb - seg_pa;
        md_mplier  = seg_dl_mag[LEVEL_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_SETUP) begin
            use_div_reg <= !below_p0 && (below_p1 || below_p2);
            neg_reg     <= seg_dl[LEVEL_W];
            base_reg    <= seg_la;
            direct_reg  <= below_p0 ? '0 : level_at_2_reg;
        end
    end

    // |product| / den, sign applied afterwards: truncation toward zero
    gsal_muldiv u_muldiv (
        .aclk     (aclk),
        .ctrl     (md_ctrl),
        .mcand    (md_mcand),
        .mplier   (md_mplier),
        .divisor  (md_den),
        .quotient (md_quot)
    );

    // quotient is below the level step, so the result stays between the two levels
    always_comb begin
        if (!use_div_reg) begin
            level_final = direct_reg;
        end else if (neg_reg) begin
            level_final = base_reg - md_quot;
        end else begin
            level_final = base_reg + md_quot;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_mean_reg      <= mean_reg;
            m_level_reg     <= level_final;
            m_ready_res_reg <= ready_res_reg;
            m_countdown_reg <= countdown_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_mean_sample = m_mean_reg;
    assign m_level       = m_level_reg;
    assign m_ready_res   = m_ready_res_reg;
    assign m_countdown   = m_countdown_reg;

endmodule
